// ===== rtl/core/dmrs_spg_pkg.sv =====
// Shared types, constants and the extra-position tables for the DMRS symbol
// position generator. No dependencies.
package dmrs_spg_pkg;

   localparam int SLOT_SYMBOLS = 14;
   localparam int SYM_W        = SLOT_SYMBOLS;
   localparam int LEN_W        = 4;
   localparam int POS_W        = 4;
   localparam int ADD_W        = 2;
   localparam int COND_W       = 4;
   localparam int HOP_W        = LEN_W - 1;

   localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(4);
   localparam logic [LEN_W-1:0] TAB_ROWS     = LEN_W'(11);
   localparam logic [HOP_W-1:0] HOP_MIN      = HOP_W'(4);
   localparam logic [HOP_W-1:0] HOP_EXT      = HOP_W'(5);
   localparam logic [HOP_W-1:0] HOP_FAR      = HOP_W'(7);
   localparam logic [POS_W-1:0] FAR_OFFSET   = POS_W'(6);
   localparam logic [POS_W-1:0] HOP2_EXT_SYM = POS_W'(4);
   localparam logic [POS_W-1:0] L0_LOW       = POS_W'(2);
   localparam logic [POS_W-1:0] L0_HIGH      = POS_W'(3);

   localparam logic MAP_TYPE_A = 1'b0;
   localparam logic MAP_TYPE_B = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [ADD_W-1:0] ADD_POS_0 = ADD_W'(0);
   localparam logic [ADD_W-1:0] ADD_POS_1 = ADD_W'(1);
   localparam logic [ADD_W-1:0] ADD_POS_2 = ADD_W'(2);
   localparam logic [ADD_W-1:0] ADD_POS_3 = ADD_W'(3);

   typedef struct packed {
      logic             map_kind;
      logic [LEN_W-1:0] alloc_len;
      logic [POS_W-1:0] first_pos;
      logic [ADD_W-1:0] add_pos;
      logic             double_sym;
      logic             hopping;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [SYM_W-1:0]  hop1_mask;
      logic [SYM_W-1:0]  hop2_mask;
      logic [COND_W-1:0] cond_mask;
   } rsp_type;

   // extra positions for lengths 4..14 (row = length - 4)
   function automatic logic [SYM_W-1:0] extra_lookup(
      input logic             kind,
      input logic [LEN_W-1:0] row,
      input logic [ADD_W-1:0] ap
   );
      logic [SYM_W-1:0] v1;
      logic [SYM_W-1:0] v2;
      logic [SYM_W-1:0] v3;
      logic [SYM_W-1:0] res;
      v1 = '0;
      v2 = '0;
      v3 = '0;
      if (kind == MAP_TYPE_A) begin
         unique case (row) inside
            4'd4, 4'd5: begin
               v1 = SYM_W'(14'h080); v2 = SYM_W'(14'h080); v3 = SYM_W'(14'h080);
            end
            4'd6, 4'd7: begin
               v1 = SYM_W'(14'h200); v2 = SYM_W'(14'h240); v3 = SYM_W'(14'h240);
            end
            4'd8: begin
               v1 = SYM_W'(14'h200); v2 = SYM_W'(14'h240); v3 = SYM_W'(14'h920);
            end
            4'd9, 4'd10: begin
               v1 = SYM_W'(14'h800); v2 = SYM_W'(14'h880); v3 = SYM_W'(14'h920);
            end
            default: begin
               v1 = '0; v2 = '0; v3 = '0;
            end
         endcase
      end else begin
         unique case (row) inside
            4'd1, 4'd2, 4'd3: begin
               v1 = SYM_W'(14'h010); v2 = SYM_W'(14'h010); v3 = SYM_W'(14'h010);
            end
            4'd4, 4'd5: begin
               v1 = SYM_W'(14'h040); v2 = SYM_W'(14'h048); v3 = SYM_W'(14'h048);
            end
            4'd6, 4'd7: begin
               v1 = SYM_W'(14'h100); v2 = SYM_W'(14'h110); v3 = SYM_W'(14'h248);
            end
            4'd8, 4'd9, 4'd10: begin
               v1 = SYM_W'(14'h400); v2 = SYM_W'(14'h420); v3 = SYM_W'(14'h248);
            end
            default: begin
               v1 = '0; v2 = '0; v3 = '0;
            end
         endcase
      end
      unique case (ap)
         ADD_POS_1: res = v1;
         ADD_POS_2: res = v2;
         ADD_POS_3: res = v3;
         default:   res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/core/dmrs_spg_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
// Depends on dmrs_spg_pkg for the payload types.
interface dmrs_spg_req_if import dmrs_spg_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dmrs_spg_rsp_if import dmrs_spg_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/dmrs_spg_calc.sv =====
// Combinational DMRS mask build for one registered request.
// Depends on dmrs_spg_pkg for types, constants and the extra-position tables.
module dmrs_spg_calc import dmrs_spg_pkg::*; (
   input  req_type req_data,
   output rsp_type rsp_data
);

   logic             kind;
   logic [LEN_W-1:0] len;
   logic [ADD_W-1:0] ap;
   logic             l0_ok;
   logic [POS_W-1:0] base;
   logic [HOP_W-1:0] hop_len;
   logic [LEN_W-1:0] row;
   logic [SYM_W-1:0] base_bit;
   logic [SYM_W-1:0] m1;
   logic [SYM_W-1:0] m2;
   logic             bad;
   logic             hop_ext;
   logic [POS_W-1:0] far_pos;

   assign kind     = req_data.map_kind;
   assign len      = req_data.alloc_len;
   assign ap       = req_data.add_pos;
   assign l0_ok    = (req_data.first_pos == L0_LOW) || (req_data.first_pos == L0_HIGH);
   assign base     = (kind == MAP_TYPE_A) ? req_data.first_pos : '0;
   assign hop_len  = len[LEN_W-1:1];
   assign row      = len - MIN_LEN;
   assign base_bit = SYM_W'(1) << base;
   assign hop_ext  = (ap == ADD_POS_1) && (hop_len >= HOP_EXT);
   assign far_pos  = (hop_len >= HOP_FAR) ? (base + FAR_OFFSET) : base;

   always_comb begin
      m1  = '0;
      m2  = '0;
      bad = (len == '0) || (len > LEN_W'(SLOT_SYMBOLS)) ||
            (req_data.double_sym && (ap > ADD_POS_1));
      if (!bad) begin
         if (req_data.hopping) begin
            if ((hop_len < HOP_MIN) || ((kind == MAP_TYPE_A) && !l0_ok)) begin
               bad = 1'b1;
            end else begin
               m1 = base_bit;
               m2 = SYM_W'(1);
               if (hop_ext) begin
                  m1 = m1 | (SYM_W'(1) << far_pos);
                  m2 = m2 | (SYM_W'(1) << HOP2_EXT_SYM);
               end
            end
         end else begin
            if ((len < MIN_LEN) || ((kind == MAP_TYPE_A) && !l0_ok) || (row >= TAB_ROWS)) begin
               bad = 1'b1;
            end else begin
               m1 = base_bit | extra_lookup(kind, row, ap);
               if (req_data.double_sym) begin
                  m1 = m1 | {m1[SYM_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_comb begin
      if (bad) begin
         rsp_data.status    = STATUS_BAD;
         rsp_data.hop1_mask = '0;
         rsp_data.hop2_mask = '0;
         rsp_data.cond_mask = '0;
      end else begin
         rsp_data.status    = STATUS_OK;
         rsp_data.hop1_mask = m1;
         rsp_data.hop2_mask = m2;
         rsp_data.cond_mask = COND_W'(1) << ap;
      end
   end

endmodule

// ===== rtl/core/dmrs_symbol_position_gen.sv =====
// DMRS symbol position generator: each request (mapping type, length, l0,
// additional position, double-symbol and hopping flags) returns the DMRS
// symbols of a 14-symbol slot as bit masks for hop 1 and hop 2, the one-hot
// additional position and a status; an invalid combination returns status 1
// with all masks zero. A request is taken every cycle while the result side
// does not stall; its result passes the input register, the table lookup and
// mask build, and the result register, and then is valid. Stalls on the
// result side back up through both registers.
// Depends on dmrs_spg_pkg, dmrs_spg_if, dmrs_spg_calc.
module dmrs_symbol_position_gen import dmrs_spg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   dmrs_spg_req_if.sink   req_ch,
   dmrs_spg_rsp_if.source rsp_ch
);

   logic    req_vld_ff;
   logic    req_vld_in;
   req_type req_data_ff;
   logic    rsp_vld_ff;
   logic    rsp_vld_in;
   rsp_type rsp_data_ff;
   rsp_type calc_data;
   logic    rsp_load;
   logic    req_load;

   dmrs_spg_calc u_calc (
      .req_data (req_data_ff),
      .rsp_data (calc_data)
   );

   assign rsp_load     = req_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_load     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !req_vld_ff || rsp_load;

   assign rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_ch.ready);
   assign req_vld_in = req_load || (req_vld_ff && !rsp_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         req_data_ff <= req_ch.payload;
      end
      if (rsp_load) begin
         rsp_data_ff <= calc_data;
      end
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.payload = rsp_data_ff;

`ifndef ASSERT_OFF
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff.status == STATUS_BAD) |->
      (rsp_data_ff.hop1_mask == '0 && rsp_data_ff.hop2_mask == '0 &&
       rsp_data_ff.cond_mask == '0))
      else $error("invalid result carries nonzero masks");

   a_ok_cond: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff.status == STATUS_OK) |->
      ($onehot(rsp_data_ff.cond_mask) && rsp_data_ff.hop1_mask != '0))
      else $error("valid result lacks cond or hop1 bits");

   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && rsp_vld_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while pipeline full and stalled");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ch.ready) |=> (rsp_vld_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

   a_load_next: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_vld_ff)
      else $error("result register lost a loaded request");
`endif

endmodule
